// ===== design/fevl_pkg.sv =====
// Shared types and constants of the fault event ring logger.
`default_nettype none

package fevl_pkg;

   localparam int ACTION_W = 2;
   localparam int CODE_W   = 5;
   localparam int LEVEL_W  = 8;
   localparam int INDEX_W  = 5;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam int IV_W   = 20;
   localparam int SEC_W  = 12;
   localparam int HOUR_W = 9;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_OBSERVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_KEY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FROZEN  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CBC     = 2'd2;

   localparam logic [CODE_W-1:0] STARTUP_RESET = 5'd1;
   localparam logic [CODE_W-1:0] SLEEP_RESET   = 5'd2;
   localparam logic [CODE_W-1:0] CBC_RESET     = 5'd3;

   localparam logic [KEY_W-1:0] CLEAR_KEY = 16'h0001;

   localparam logic [IV_W-1:0]   IV_MAX       = 20'hFFFFF;
   localparam logic [IV_W-1:0]   IV_MINUTE    = 20'd60;
   localparam logic [IV_W-1:0]   IV_WEEK      = 20'd604800;
   localparam logic [SEC_W-1:0]  SEC_LAST     = 12'd3599;
   localparam logic [BYTE_W-1:0] TC_MINUTE    = 8'd171;
   localparam logic [BYTE_W-1:0] TC_OVER_WEEK = 8'd170;
   localparam logic [BYTE_W-1:0] TC_STARTUP   = 8'd0;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef struct packed {
      logic               tick;
      logic               restart;
   } timer_ctl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                logged;
      logic [SLOT_W-1:0]   slot;
      logic [BYTE_W-1:0]   rec_event;
      logic [BYTE_W-1:0]   rec_time;
      logic [SLOT_W-1:0]   next_pointer;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/fault_event_ring_logger.sv =====
// Fault event ring logger top level: control, record store and result queue.
//
// Usage:
//   req_*  carries one command per transfer: one-second tick, observe event,
//          read record (newest first), or clear log (key 1 only).
//   rsp_*  returns exactly one result per command, in command order.
//   csr_*  writes the start-up, sleep and CBC event codes; csr_ready is
//          always high, write only while no command is outstanding.
// Timing:
//   Tick, observe and clear results are pushed into the result queue in the
//   transfer cycle. A read moves to S_READ, where the registered read data
//   of the record RAM is used and its result is pushed; no command is taken
//   in S_READ. Throughput is one command per cycle while the queue has room
//   and the block is idle.
// Stalls:
//   Results wait in a two-entry queue; req_ready is high in the idle state
//   while the queue has room, so one command is taken while an earlier result waits.
// Reset:
//   Synchronous; clears the record valid bits, pointer, interval counter,
//   edge flags, CBC value, freeze flag and restores the default codes.
//   There is no memory clearing pass.
`default_nettype none

module fault_event_ring_logger #(
   parameter int LOG_DEPTH   = 30,
   parameter int EVENT_COUNT = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fevl_pkg::ACTION_W-1:0]    req_action,
   input  wire logic [fevl_pkg::CODE_W-1:0]      req_event_id,
   input  wire logic [fevl_pkg::LEVEL_W-1:0]     req_level,
   input  wire logic [fevl_pkg::INDEX_W-1:0]     req_read_index,
   input  wire logic [fevl_pkg::KEY_W-1:0]       req_clear_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [fevl_pkg::STATUS_W-1:0]    rsp_status,
   output logic                                  rsp_logged,
   output logic      [fevl_pkg::SLOT_W-1:0]      rsp_slot,
   output logic      [fevl_pkg::BYTE_W-1:0]      rsp_rec_event,
   output logic      [fevl_pkg::BYTE_W-1:0]      rsp_rec_time,
   output logic      [fevl_pkg::SLOT_W-1:0]      rsp_next_pointer,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fevl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fevl_pkg::CODE_W-1:0]      csr_data
);

   localparam int AW    = $clog2(LOG_DEPTH);
   localparam int PW    = $clog2(LOG_DEPTH + 1);
   localparam int SW    = PW + 1;
   localparam int EAW   = (EVENT_COUNT > 2) ? $clog2(EVENT_COUNT) : 1;
   localparam int RIDX_N = 2 ** fevl_pkg::INDEX_W;
   localparam int DW    = 2 * fevl_pkg::BYTE_W;

   function automatic logic [RIDX_N*AW-1:0] build_mod_tab();
      logic [RIDX_N*AW-1:0] tab;
      tab = '0;
      for (int i = 0; i < RIDX_N; i++) begin
         tab[i*AW +: AW] = AW'(i % LOG_DEPTH);
      end
      return tab;
   endfunction

   localparam logic [RIDX_N*AW-1:0] MOD_TAB = build_mod_tab();

   // configuration
   logic [fevl_pkg::CODE_W-1:0] startup_ff, sleep_ff, cbc_ff;

   // control state
   fevl_pkg::state_type         state_ff, state_in;
   logic [PW-1:0]               wp_ff, wp_in;
   logic                        frozen_ff, frozen_in;
   logic [fevl_pkg::LEVEL_W-1:0] cbc_val_ff, cbc_val_in;
   logic [EVENT_COUNT-1:0]      act_ff, act_in;
   logic [LOG_DEPTH-1:0]        vld_ff, vld_in;
   logic [AW-1:0]               rslot_ff;
   logic                        rvld_ff;

   // datapath
   logic                        accept;
   logic                        is_startup, is_sleep, is_cbc, is_plain;
   logic [8:0]                  ev_ext;
   logic [EAW-1:0]              ev_idx;
   logic                        do_write;
   logic [AW-1:0]               ws;
   logic [AW-1:0]               ridx;
   logic [SW-1:0]               rsum;
   logic [AW-1:0]               rslot;
   logic [fevl_pkg::BYTE_W-1:0] time_code;
   logic [fevl_pkg::BYTE_W-1:0] wr_time;
   logic [DW-1:0]               rd_data;
   logic                        ram_rd_en;
   fevl_pkg::timer_ctl_type     tctl;
   fevl_pkg::rsp_type           res, out_data;
   logic                        push, room;
   logic [8:0]                  wp_ext, ws_ext, rs_ext, rq_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_ff <= fevl_pkg::STARTUP_RESET;
         sleep_ff   <= fevl_pkg::SLEEP_RESET;
         cbc_ff     <= fevl_pkg::CBC_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fevl_pkg::CSR_STARTUP: startup_ff <= csr_data;
            fevl_pkg::CSR_SLEEP:   sleep_ff   <= csr_data;
            fevl_pkg::CSR_CBC:     cbc_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // event classification
   assign ev_ext     = 9'(req_event_id);
   assign ev_idx     = ev_ext[EAW-1:0];
   assign is_startup = (req_event_id == startup_ff);
   assign is_sleep   = !is_startup && (req_event_id == sleep_ff);
   assign is_cbc     = !is_startup && !is_sleep && (req_event_id == cbc_ff);
   assign is_plain   = !is_startup && !is_sleep && !is_cbc &&
                       (ev_ext < 9'(EVENT_COUNT));

   // write slot: wrap a full pointer to zero
   assign ws      = (wp_ff >= PW'(LOG_DEPTH)) ? '0 : wp_ff[AW-1:0];
   assign wr_time = is_startup ? fevl_pkg::TC_STARTUP : time_code;

   // read slot counted from newest
   assign ridx  = MOD_TAB[req_read_index*AW +: AW];
   assign rsum  = SW'(wp_ff) + SW'(LOG_DEPTH - 1) - SW'(ridx);
   assign rslot = (rsum >= SW'(LOG_DEPTH)) ? AW'(rsum - SW'(LOG_DEPTH)) : AW'(rsum);

   assign accept    = req_valid && req_ready;
   assign ram_rd_en = accept && (req_action == fevl_pkg::ACT_READ);

   always_comb begin
      do_write = 1'b0;
      if (req_level != '0) begin
         do_write = is_startup || is_sleep || (is_plain && !act_ff[ev_idx]);
      end
      if (is_cbc && (req_level != cbc_val_ff)) begin
         do_write = 1'b1;
      end
      if (!accept || frozen_ff || (req_action != fevl_pkg::ACT_OBSERVE)) begin
         do_write = 1'b0;
      end
   end

   assign tctl.tick    = accept && !frozen_ff && (req_action == fevl_pkg::ACT_TICK);
   assign tctl.restart = do_write;

   fevl_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tctl),
      .time_code (time_code)
   );

   fevl_ram #(
      .WIDTH (DW),
      .DEPTH (LOG_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (ws),
      .wr_data ({fevl_pkg::BYTE_W'(req_event_id), wr_time}),
      .rd_en   (ram_rd_en),
      .rd_addr (rslot),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      frozen_in  = frozen_ff;
      cbc_val_in = cbc_val_ff;
      act_in     = act_ff;
      vld_in     = vld_ff;
      req_ready  = 1'b0;
      push       = 1'b0;
      case (state_ff)
         fevl_pkg::S_IDLE: begin
            req_ready = room;
            if (accept) begin
               case (req_action)
                  fevl_pkg::ACT_READ: begin
                     state_in = fevl_pkg::S_READ;
                  end
                  fevl_pkg::ACT_CLEAR: begin
                     push = 1'b1;
                     if (req_clear_key == fevl_pkg::CLEAR_KEY) begin
                        wp_in     = '0;
                        frozen_in = 1'b1;
                        vld_in    = '0;
                     end
                  end
                  fevl_pkg::ACT_OBSERVE: begin
                     push = 1'b1;
                     if (!frozen_ff) begin
                        if (is_cbc) begin
                           cbc_val_in = req_level;
                        end
                        if (is_plain) begin
                           if (!act_ff[ev_idx] && (req_level != '0)) begin
                              act_in[ev_idx] = 1'b1;
                           end else if (act_ff[ev_idx] && (req_level == '0)) begin
                              act_in[ev_idx] = 1'b0;
                           end
                        end
                     end
                     if (do_write) begin
                        wp_in      = PW'(ws) + PW'(1);
                        vld_in[ws] = 1'b1;
                     end
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         fevl_pkg::S_READ: begin
            push     = 1'b1;
            state_in = fevl_pkg::S_IDLE;
         end
         default: begin
            state_in = fevl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fevl_pkg::S_IDLE;
         wp_ff      <= '0;
         frozen_ff  <= 1'b0;
         cbc_val_ff <= '0;
         act_ff     <= '0;
         vld_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         frozen_ff  <= frozen_in;
         cbc_val_ff <= cbc_val_in;
         act_ff     <= act_in;
         vld_ff     <= vld_in;
      end
   end

   // hold read slot and its valid bit for the data cycle
   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         rslot_ff <= rslot;
         rvld_ff  <= vld_ff[rslot];
      end
   end

   assign wp_ext = 9'(wp_ff);
   assign ws_ext = 9'(ws);
   assign rs_ext = 9'(rslot_ff);
   assign rq_ext = 9'(wp_in);

   always_comb begin
      res.status       = fevl_pkg::ST_OK;
      res.logged       = 1'b0;
      res.slot         = '0;
      res.rec_event    = '0;
      res.rec_time     = '0;
      res.next_pointer = rq_ext[fevl_pkg::SLOT_W-1:0];
      if (state_ff == fevl_pkg::S_READ) begin
         res.slot         = rs_ext[fevl_pkg::SLOT_W-1:0];
         res.next_pointer = wp_ext[fevl_pkg::SLOT_W-1:0];
         if (rvld_ff) begin
            res.rec_event = rd_data[DW-1:fevl_pkg::BYTE_W];
            res.rec_time  = rd_data[fevl_pkg::BYTE_W-1:0];
         end
      end else begin
         case (req_action)
            fevl_pkg::ACT_TICK: begin
               if (frozen_ff) begin
                  res.status = fevl_pkg::ST_FROZEN;
               end
            end
            fevl_pkg::ACT_OBSERVE: begin
               if (frozen_ff) begin
                  res.status = fevl_pkg::ST_FROZEN;
               end else if (do_write) begin
                  res.logged    = 1'b1;
                  res.slot      = ws_ext[fevl_pkg::SLOT_W-1:0];
                  res.rec_event = fevl_pkg::BYTE_W'(req_event_id);
                  res.rec_time  = wr_time;
               end
            end
            fevl_pkg::ACT_CLEAR: begin
               if (req_clear_key != fevl_pkg::CLEAR_KEY) begin
                  res.status = fevl_pkg::ST_BAD_KEY;
               end
            end
            default: ;
         endcase
      end
   end

   fevl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_status       = out_data.status;
   assign rsp_logged       = out_data.logged;
   assign rsp_slot         = out_data.slot;
   assign rsp_rec_event    = out_data.rec_event;
   assign rsp_rec_time     = out_data.rec_time;
   assign rsp_next_pointer = out_data.next_pointer;

endmodule

`default_nettype wire

// ===== design/fevl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fevl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 30
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/fevl_timer.sv =====
// Saturating interval counter with hour tracking and time code encoding.
`default_nettype none

module fevl_timer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fevl_pkg::timer_ctl_type ctl,
   output logic [fevl_pkg::BYTE_W-1:0] time_code
);

   logic [fevl_pkg::IV_W-1:0]   iv_ff, iv_in;
   logic [fevl_pkg::SEC_W-1:0]  sec_ff, sec_in;
   logic [fevl_pkg::HOUR_W-1:0] hr_ff, hr_in;
   logic [fevl_pkg::HOUR_W-1:0] hr_up;

   always_comb begin
      iv_in  = iv_ff;
      sec_in = sec_ff;
      hr_in  = hr_ff;
      if (ctl.restart) begin
         iv_in  = '0;
         sec_in = '0;
         hr_in  = '0;
      end else if (ctl.tick && (iv_ff != fevl_pkg::IV_MAX)) begin
         iv_in = iv_ff + fevl_pkg::IV_W'(1);
         if (sec_ff == fevl_pkg::SEC_LAST) begin
            sec_in = '0;
            hr_in  = hr_ff + fevl_pkg::HOUR_W'(1);
         end else begin
            sec_in = sec_ff + fevl_pkg::SEC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff  <= '0;
         sec_ff <= '0;
         hr_ff  <= '0;
      end else begin
         iv_ff  <= iv_in;
         sec_ff <= sec_in;
         hr_ff  <= hr_in;
      end
   end

   assign hr_up = hr_ff + fevl_pkg::HOUR_W'(sec_ff != '0);

   always_comb begin
      if (iv_ff <= fevl_pkg::IV_MINUTE) begin
         time_code = fevl_pkg::TC_MINUTE;
      end else if (iv_ff <= fevl_pkg::IV_WEEK) begin
         time_code = hr_up[fevl_pkg::BYTE_W-1:0];
      end else begin
         time_code = fevl_pkg::TC_OVER_WEEK;
      end
   end

endmodule

`default_nettype wire

// ===== design/fevl_outq.sv =====
// Two-entry result queue between the logger core and the result channel.
`default_nettype none

module fevl_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fevl_pkg::rsp_type push_data,
   output logic                   room,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output fevl_pkg::rsp_type      out_data
);

   fevl_pkg::rsp_type ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign room      = (cnt_ff != 2'd2);
   assign pop       = out_valid && out_ready;
   assign out_data  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the fault event ring logger with a queued driver and a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = 30;
   localparam int CODE_COUNT  = 32;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      logic [fevl_pkg::ACTION_W-1:0] action;
      logic [fevl_pkg::CODE_W-1:0]   event_id;
      logic [fevl_pkg::LEVEL_W-1:0]  level;
      logic [fevl_pkg::INDEX_W-1:0]  read_index;
      logic [fevl_pkg::KEY_W-1:0]    clear_key;
      bit                            drain;
   } cmd_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [fevl_pkg::ACTION_W-1:0]  req_action = fevl_pkg::ACT_TICK;
   logic [fevl_pkg::CODE_W-1:0]    req_event_id = '0;
   logic [fevl_pkg::LEVEL_W-1:0]   req_level = '0;
   logic [fevl_pkg::INDEX_W-1:0]   req_read_index = '0;
   logic [fevl_pkg::KEY_W-1:0]     req_clear_key = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [fevl_pkg::STATUS_W-1:0]  rsp_status;
   logic                           rsp_logged;
   logic [fevl_pkg::SLOT_W-1:0]    rsp_slot;
   logic [fevl_pkg::BYTE_W-1:0]    rsp_rec_event;
   logic [fevl_pkg::BYTE_W-1:0]    rsp_rec_time;
   logic [fevl_pkg::SLOT_W-1:0]    rsp_next_pointer;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [fevl_pkg::CSR_IDX_W-1:0] csr_index = fevl_pkg::CSR_STARTUP;
   logic [fevl_pkg::CODE_W-1:0]    csr_data = '0;

   // predictor state
   logic [fevl_pkg::BYTE_W-1:0]    ring_event [RING_DEPTH] = '{default: '0};
   logic [fevl_pkg::BYTE_W-1:0]    ring_time [RING_DEPTH] = '{default: '0};
   int                             ring_wr = 0;
   logic [fevl_pkg::IV_W-1:0]      idle_secs = '0;
   bit                             armed [CODE_COUNT] = '{default: 1'b0};
   logic [fevl_pkg::LEVEL_W-1:0]   cbc_seen = '0;
   bit                             log_frozen = 1'b0;
   logic [fevl_pkg::CODE_W-1:0]    code_startup = fevl_pkg::STARTUP_RESET;
   logic [fevl_pkg::CODE_W-1:0]    code_sleep = fevl_pkg::SLEEP_RESET;
   logic [fevl_pkg::CODE_W-1:0]    code_cbc = fevl_pkg::CBC_RESET;

   cmd_type                        pending_q [$];
   fevl_pkg::rsp_type              expected_q [$];
   cmd_type                        next_cmd;
   cmd_type                        seen_cmd;
   fevl_pkg::rsp_type              want;
   bit                             req_taken = 1'b0;
   bit                             quiet = 1'b0;
   int                             gap_left = 0;
   int                             stall_left = 0;
   int                             queued_count = 0;
   int                             cycle_count = 0;
   int                             err_count = 0;
   int                             n_accepted = 0;
   int                             n_results = 0;
   int                             n_logged = 0;
   int                             n_reads = 0;
   int                             n_frozen = 0;
   int                             n_bad_key = 0;

   fault_event_ring_logger u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_event_id     (req_event_id),
      .req_level        (req_level),
      .req_read_index   (req_read_index),
      .req_clear_key    (req_clear_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_logged       (rsp_logged),
      .rsp_slot         (rsp_slot),
      .rsp_rec_event    (rsp_rec_event),
      .rsp_rec_time     (rsp_rec_time),
      .rsp_next_pointer (rsp_next_pointer),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [fevl_pkg::BYTE_W-1:0] coarse_time(
         logic [fevl_pkg::IV_W-1:0] secs);
      int unsigned s;
      s = secs;
      if (s <= fevl_pkg::IV_MINUTE) return fevl_pkg::TC_MINUTE;
      if (s <= fevl_pkg::IV_WEEK) return fevl_pkg::BYTE_W'((s + 3599) / 3600);
      return fevl_pkg::TC_OVER_WEEK;
   endfunction

   function automatic fevl_pkg::rsp_type log_step(cmd_type c);
      fevl_pkg::rsp_type r;
      bit                hit;
      bit                zero_time;
      int unsigned       idx;
      int unsigned       pos;
      r = '0;
      hit = 1'b0;
      zero_time = 1'b0;
      case (c.action)
         fevl_pkg::ACT_TICK: begin
            if (log_frozen) r.status = fevl_pkg::ST_FROZEN;
            else if (idle_secs != fevl_pkg::IV_MAX) idle_secs++;
         end
         fevl_pkg::ACT_OBSERVE: begin
            if (log_frozen) begin
               r.status = fevl_pkg::ST_FROZEN;
            end else begin
               if (c.event_id == code_startup) begin
                  hit = (c.level != 0);
                  zero_time = 1'b1;
               end else if (c.event_id == code_sleep) begin
                  hit = (c.level != 0);
               end else if (c.event_id == code_cbc) begin
                  if (c.level != cbc_seen) begin
                     cbc_seen = c.level;
                     hit = 1'b1;
                  end
               end else if (!armed[c.event_id]) begin
                  if (c.level != 0) begin
                     hit = 1'b1;
                     armed[c.event_id] = 1'b1;
                  end
               end else if (c.level == 0) begin
                  armed[c.event_id] = 1'b0;
               end
               if (hit) begin
                  if (ring_wr >= RING_DEPTH) ring_wr = 0;
                  r.logged = 1'b1;
                  r.slot = fevl_pkg::SLOT_W'(ring_wr);
                  r.rec_event = fevl_pkg::BYTE_W'(c.event_id);
                  r.rec_time = zero_time ? fevl_pkg::TC_STARTUP : coarse_time(idle_secs);
                  idle_secs = '0;
                  ring_event[ring_wr] = r.rec_event;
                  ring_time[ring_wr] = r.rec_time;
                  ring_wr++;
               end
            end
         end
         fevl_pkg::ACT_READ: begin
            idx = c.read_index % RING_DEPTH;
            pos = (ring_wr % (RING_DEPTH + 1) + RING_DEPTH - 1 - idx) % RING_DEPTH;
            r.slot = fevl_pkg::SLOT_W'(pos);
            r.rec_event = ring_event[pos];
            r.rec_time = ring_time[pos];
         end
         fevl_pkg::ACT_CLEAR: begin
            if (c.clear_key == fevl_pkg::CLEAR_KEY) begin
               ring_event = '{default: '0};
               ring_time = '{default: '0};
               ring_wr = 0;
               log_frozen = 1'b1;
            end else begin
               r.status = fevl_pkg::ST_BAD_KEY;
            end
         end
      endcase
      r.next_pointer = fevl_pkg::SLOT_W'(ring_wr);
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("rsp_%s: expected %0d, got %0d", name, exp_val, act_val);
         err_count++;
      end
   endfunction

   function automatic void push_cmd(logic [fevl_pkg::ACTION_W-1:0] act,
                                    logic [fevl_pkg::CODE_W-1:0] ev,
                                    logic [fevl_pkg::LEVEL_W-1:0] lvl,
                                    logic [fevl_pkg::INDEX_W-1:0] idx,
                                    logic [fevl_pkg::KEY_W-1:0] key, bit drain = 1'b0);
      cmd_type c;
      c.action = act;
      c.event_id = ev;
      c.level = lvl;
      c.read_index = idx;
      c.clear_key = key;
      c.drain = drain;
      pending_q.push_back(c);
      queued_count++;
   endfunction

   function automatic void push_observe(logic [fevl_pkg::CODE_W-1:0] ev,
                                        logic [fevl_pkg::LEVEL_W-1:0] lvl,
                                        bit drain = 1'b0);
      push_cmd(fevl_pkg::ACT_OBSERVE, ev, lvl, fevl_pkg::INDEX_W'($urandom),
               fevl_pkg::KEY_W'($urandom), drain);
   endfunction

   function automatic void push_ticks(int n);
      repeat (n)
         push_cmd(fevl_pkg::ACT_TICK, fevl_pkg::CODE_W'($urandom),
                  fevl_pkg::LEVEL_W'($urandom), fevl_pkg::INDEX_W'($urandom),
                  fevl_pkg::KEY_W'($urandom));
   endfunction

   function automatic void push_read(logic [fevl_pkg::INDEX_W-1:0] idx);
      push_cmd(fevl_pkg::ACT_READ, fevl_pkg::CODE_W'($urandom), fevl_pkg::LEVEL_W'($urandom),
               idx, fevl_pkg::KEY_W'($urandom));
   endfunction

   function automatic void push_clear(logic [fevl_pkg::KEY_W-1:0] key);
      push_cmd(fevl_pkg::ACT_CLEAR, fevl_pkg::CODE_W'($urandom), fevl_pkg::LEVEL_W'($urandom),
               fevl_pkg::INDEX_W'($urandom), key);
   endfunction

   function automatic logic [fevl_pkg::KEY_W-1:0] bad_key();
      logic [fevl_pkg::KEY_W-1:0] key;
      key = fevl_pkg::KEY_W'($urandom);
      if (key == fevl_pkg::CLEAR_KEY) key = ~fevl_pkg::CLEAR_KEY;
      return key;
   endfunction

   function automatic logic [fevl_pkg::CODE_W-1:0] pick_code();
      case ($urandom_range(0, 5))
         0: return code_startup;
         1: return code_sleep;
         2: return code_cbc;
         default: return fevl_pkg::CODE_W'($urandom);
      endcase
   endfunction

   function automatic logic [fevl_pkg::LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0, 1: return '0;
         2: return '1;
         3: return fevl_pkg::LEVEL_W'(1);
         default: return fevl_pkg::LEVEL_W'($urandom);
      endcase
   endfunction

   function automatic void push_random_mix(int target);
      int                          start;
      logic [fevl_pkg::CODE_W-1:0] ev;
      start = queued_count;
      while (queued_count - start < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // rising edge, short pause, then a random level on the same event
               ev = pick_code();
               push_observe(ev, fevl_pkg::LEVEL_W'($urandom_range(1, 255)),
                            $urandom_range(0, 39) == 0);
               push_ticks($urandom_range(0, 3));
               push_observe(ev, pick_level());
            end
            3: begin
               push_ticks(($urandom_range(0, 7) == 0) ? $urandom_range(55, 66)
                                                        : $urandom_range(1, 6));
               push_observe(pick_code(), pick_level());
            end
            4, 5: push_read(($urandom_range(0, 9) == 0)
                               ? fevl_pkg::INDEX_W'($urandom_range(30, 31))
                               : fevl_pkg::INDEX_W'($urandom_range(0, 29)));
            6: push_clear(bad_key());
            7, 8: push_observe(fevl_pkg::CODE_W'($urandom), pick_level());
            default: push_cmd(fevl_pkg::ACTION_W'($urandom_range(fevl_pkg::ACT_TICK,
                                                                 fevl_pkg::ACT_READ)),
                              fevl_pkg::CODE_W'($urandom), fevl_pkg::LEVEL_W'($urandom),
                              fevl_pkg::INDEX_W'($urandom), fevl_pkg::KEY_W'($urandom));
         endcase
      end
   endfunction

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
   endtask

   task automatic write_code(logic [fevl_pkg::CSR_IDX_W-1:0] idx,
                             logic [fevl_pkg::CODE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_codes(logic [fevl_pkg::CODE_W-1:0] st, logic [fevl_pkg::CODE_W-1:0] sl,
                            logic [fevl_pkg::CODE_W-1:0] cb);
      write_code(fevl_pkg::CSR_STARTUP, st);
      write_code(fevl_pkg::CSR_SLEEP, sl);
      write_code(fevl_pkg::CSR_CBC, cb);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until transfer
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && expected_q.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         next_cmd = pending_q.pop_front();
         req_valid      <= 1'b1;
         req_action     <= next_cmd.action;
         req_event_id   <= next_cmd.event_id;
         req_level      <= next_cmd.level;
         req_read_index <= next_cmd.read_index;
         req_clear_key  <= next_cmd.clear_key;
         if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 18);
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top: errors");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with no command outstanding");
               err_count++;
            end else begin
               want = expected_q.pop_front();
               n_results++;
               check_field("status", want.status, rsp_status);
               check_field("logged", want.logged, rsp_logged);
               check_field("slot", want.slot, rsp_slot);
               check_field("rec_event", want.rec_event, rsp_rec_event);
               check_field("rec_time", want.rec_time, rsp_rec_time);
               check_field("next_pointer", want.next_pointer, rsp_next_pointer);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fevl_pkg::CSR_STARTUP: code_startup = csr_data;
               fevl_pkg::CSR_SLEEP:   code_sleep = csr_data;
               fevl_pkg::CSR_CBC:     code_cbc = csr_data;
               default: ;
            endcase
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            seen_cmd.action     = req_action;
            seen_cmd.event_id   = req_event_id;
            seen_cmd.level      = req_level;
            seen_cmd.read_index = req_read_index;
            seen_cmd.clear_key  = req_clear_key;
            seen_cmd.drain      = 1'b0;
            want = log_step(seen_cmd);
            expected_q.push_back(want);
            n_accepted++;
            if (want.logged) n_logged++;
            if (req_action == fevl_pkg::ACT_READ) n_reads++;
            if (want.status == fevl_pkg::ST_FROZEN) n_frozen++;
            if (want.status == fevl_pkg::ST_BAD_KEY) n_bad_key++;
         end
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      push_read(fevl_pkg::INDEX_W'(0));
      push_observe(fevl_pkg::STARTUP_RESET, 8'd0);
      push_observe(fevl_pkg::STARTUP_RESET, 8'd255);
      push_observe(fevl_pkg::STARTUP_RESET, 8'd255);
      push_observe(fevl_pkg::SLEEP_RESET, 8'd0);
      push_observe(fevl_pkg::SLEEP_RESET, 8'd1);
      push_observe(fevl_pkg::CBC_RESET, 8'd0);
      push_observe(fevl_pkg::CBC_RESET, 8'd128);
      push_observe(fevl_pkg::CBC_RESET, 8'd128);
      push_observe(fevl_pkg::CBC_RESET, 8'd0);
      push_observe(5'd31, 8'd255);
      push_observe(5'd31, 8'd1);
      push_observe(5'd31, 8'd0);
      push_observe(5'd31, 8'd1);
      push_observe(5'd0, 8'd1, 1'b1);
      push_ticks(60);
      push_observe(5'd4, 8'd9);
      push_ticks(61);
      push_observe(5'd5, 8'd3);
      push_ticks(5);
      push_observe(fevl_pkg::STARTUP_RESET, 8'd7);
      push_clear(16'h0000);
      push_clear(16'hFFFF);
      push_clear(16'hFFFE);
      push_read(fevl_pkg::INDEX_W'(0));
      push_read(fevl_pkg::INDEX_W'(29));
      push_read(fevl_pkg::INDEX_W'(30));
      push_read(fevl_pkg::INDEX_W'(31));
      wait_drained();

      push_random_mix(200);
      wait_drained();
      set_codes(5'd0, 5'd31, 5'd31);
      push_random_mix(200);
      wait_drained();
      set_codes(5'd7, 5'd7, 5'd7);
      push_random_mix(200);
      wait_drained();
      set_codes(5'd31, 5'd0, 5'd0);
      push_random_mix(200);
      wait_drained();
      set_codes(fevl_pkg::CODE_W'($urandom), fevl_pkg::CODE_W'($urandom),
                fevl_pkg::CODE_W'($urandom));
      push_random_mix(200);
      wait_drained();

      // accepted clear freezes logging for the rest of the run
      quiet = 1'b1;
      push_clear(fevl_pkg::CLEAR_KEY);
      push_read(fevl_pkg::INDEX_W'(0));
      push_ticks(3);
      push_observe(code_startup, 8'd1);
      push_observe(5'd20, 8'd255);
      push_read(fevl_pkg::INDEX_W'(29));
      push_clear(bad_key());
      push_clear(fevl_pkg::CLEAR_KEY);
      push_read(fevl_pkg::INDEX_W'(31));
      wait_drained();
      repeat (8) @(posedge clock);

      $display("summary: %0d commands, %0d results checked, %0d records written, %0d reads",
               n_accepted, n_results, n_logged, n_reads);
      $display("summary: %0d rejected clears, %0d frozen drops, %0d mismatches",
               n_bad_key, n_frozen, err_count);
      if (err_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
